FILE: design/tqpr_pkg.sv
`default_nettype none

package tqpr_pkg;

   localparam int unsigned FRAMES_DEFAULT = 1024;
   localparam int unsigned FRAME_W        = 10;
   localparam int unsigned LIMIT_W        = 11;
   localparam int unsigned SOURCE_W       = 2;
   localparam int unsigned LIMIT_MAX      = 2047;

   // request codes
   localparam logic FUNC_REF   = 1'b0;
   localparam logic FUNC_EVICT = 1'b1;

   // victim source codes
   localparam logic [SOURCE_W-1:0] SRC_PROB = 2'd0;
   localparam logic [SOURCE_W-1:0] SRC_MAIN = 2'd1;
   localparam logic [SOURCE_W-1:0] SRC_NONE = 2'd2;

   typedef enum logic [1:0] {
      CLASS_NONE = 2'd0,
      CLASS_PROB = 2'd1,
      CLASS_MAIN = 2'd2
   } class_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_READY,
      ST_READ,
      ST_UNLINK,
      ST_APPEND,
      ST_LINK,
      ST_RETIRE
   } state_type;

   // per-field write enables of the frame memory
   typedef struct packed {
      logic cls;
      logic nxt;
      logic prv;
   } mem_we_type;

endpackage

`default_nettype wire

FILE: design/tqpr_ifs.sv
`default_nettype none

interface tqpr_req_if;
   import tqpr_pkg::*;
   logic               valid;
   logic               ready;
   logic               func;
   logic [FRAME_W-1:0] frame;
   modport source (output valid, output func, output frame, input ready);
   modport sink (input valid, input func, input frame, output ready);
endinterface

interface tqpr_rsp_if;
   import tqpr_pkg::*;
   logic                valid;
   logic                ready;
   logic [FRAME_W-1:0]  victim;
   logic [SOURCE_W-1:0] victim_source;
   modport source (output valid, output victim, output victim_source, input ready);
   modport sink (input valid, input victim, input victim_source, output ready);
endinterface

interface tqpr_csr_if;
   import tqpr_pkg::*;
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] probation_limit;
   modport source (output valid, output probation_limit, input ready);
   modport sink (input valid, input probation_limit, output ready);
endinterface

`default_nettype wire

FILE: design/tqpr_link_mem.sv
`default_nettype none

module tqpr_link_mem #(
   parameter int unsigned FRAMES = tqpr_pkg::FRAMES_DEFAULT
) (
   input  wire                                clock,
   input  wire tqpr_pkg::mem_we_type          we,
   input  wire [$clog2(FRAMES)-1:0]           wr_addr,
   input  wire tqpr_pkg::class_type           wr_class,
   input  wire [$clog2(FRAMES+1)-1:0]         wr_next,
   input  wire [$clog2(FRAMES+1)-1:0]         wr_prev,
   input  wire                                rd_en,
   input  wire [$clog2(FRAMES)-1:0]           rd_addr,
   output tqpr_pkg::class_type                rd_class,
   output logic [$clog2(FRAMES+1)-1:0]        rd_next,
   output logic [$clog2(FRAMES+1)-1:0]        rd_prev
);
   import tqpr_pkg::*;

   localparam int unsigned LW = $clog2(FRAMES + 1);

   // one entry per frame: class, next link, prev link, written field by field
   class_type         class_mem [FRAMES];
   logic [LW-1:0]     next_mem  [FRAMES];
   logic [LW-1:0]     prev_mem  [FRAMES];

   class_type         rd_class_ff;
   logic [LW-1:0]     rd_next_ff;
   logic [LW-1:0]     rd_prev_ff;

   always_ff @(posedge clock) begin
      if (we.cls) begin
         class_mem[wr_addr] <= wr_class;
      end
      if (we.nxt) begin
         next_mem[wr_addr] <= wr_next;
      end
      if (we.prv) begin
         prev_mem[wr_addr] <= wr_prev;
      end
      if (rd_en) begin
         rd_class_ff <= class_mem[rd_addr];
         rd_next_ff  <= next_mem[rd_addr];
         rd_prev_ff  <= prev_mem[rd_addr];
      end
   end

   assign rd_class = rd_class_ff;
   assign rd_next  = rd_next_ff;
   assign rd_prev  = rd_prev_ff;

endmodule

`default_nettype wire

FILE: design/tqpr_seq.sv
`default_nettype none

module tqpr_seq #(
   parameter int unsigned FRAMES = tqpr_pkg::FRAMES_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire                                  req_func,
   input  wire [tqpr_pkg::FRAME_W-1:0]          req_frame,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [tqpr_pkg::FRAME_W-1:0]         rsp_victim,
   output logic [tqpr_pkg::SOURCE_W-1:0]        rsp_victim_source,
   input  wire                                  csr_valid,
   input  wire [tqpr_pkg::LIMIT_W-1:0]          csr_probation_limit,
   output tqpr_pkg::mem_we_type                 mem_we,
   output logic [$clog2(FRAMES)-1:0]            mem_wr_addr,
   output tqpr_pkg::class_type                  mem_wr_class,
   output logic [$clog2(FRAMES+1)-1:0]          mem_wr_next,
   output logic [$clog2(FRAMES+1)-1:0]          mem_wr_prev,
   output logic                                 mem_rd_en,
   output logic [$clog2(FRAMES)-1:0]            mem_rd_addr,
   input  wire tqpr_pkg::class_type             mem_rd_class,
   input  wire [$clog2(FRAMES+1)-1:0]           mem_rd_next,
   input  wire [$clog2(FRAMES+1)-1:0]           mem_rd_prev
);
   import tqpr_pkg::*;

   localparam int unsigned IW = $clog2(FRAMES);
   localparam int unsigned LW = $clog2(FRAMES + 1);
   localparam logic [LW-1:0] NIL = LW'(FRAMES);
   localparam logic [IW-1:0] LAST = IW'(FRAMES - 1);
   localparam int unsigned LIMIT_RAW = FRAMES / 10;
   localparam int unsigned LIMIT_RESET = (LIMIT_RAW == 0) ? 1 :
                                         ((LIMIT_RAW > LIMIT_MAX) ? LIMIT_MAX : LIMIT_RAW);

   state_type            state_ff, state_in;
   logic [IW-1:0]        clr_ff, clr_in;
   logic                 func_ff, func_in;
   logic [IW-1:0]        item_ff, item_in;
   logic                 sel_main_ff, sel_main_in;
   logic [SOURCE_W-1:0]  src_ff, src_in;
   logic [LW-1:0]        old_tail_ff, old_tail_in;
   logic [LW-1:0]        prob_head_ff, prob_head_in;
   logic [LW-1:0]        prob_tail_ff, prob_tail_in;
   logic [LW-1:0]        main_head_ff, main_head_in;
   logic [LW-1:0]        main_tail_ff, main_tail_in;
   logic [LW-1:0]        prob_cnt_ff, prob_cnt_in;
   logic [LW-1:0]        main_cnt_ff, main_cnt_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]   rsp_victim_ff, rsp_victim_in;
   logic [SOURCE_W-1:0]  rsp_src_ff, rsp_src_in;

   logic                 prob_live;
   logic                 main_live;
   logic                 req_in_range;
   logic [IW-1:0]        req_idx;
   logic [LW-1:0]        ev_victim;
   logic [SOURCE_W-1:0]  ev_src;
   logic                 ev_main;
   logic                 rd_sel_main;

   assign prob_live    = (prob_head_ff < NIL);
   assign main_live    = (main_head_ff < NIL);
   assign req_in_range = (32'(req_frame) < 32'(FRAMES));
   assign req_idx      = IW'(req_frame);
   assign rd_sel_main  = (func_ff == FUNC_REF) ? (mem_rd_class != CLASS_PROB) : sel_main_ff;

   // victim choice from the queue heads and counts
   always_comb begin
      ev_victim = '0;
      ev_src    = SRC_NONE;
      ev_main   = 1'b0;
      if ((32'(prob_cnt_ff) > 32'(limit_ff)) && prob_live) begin
         ev_victim = prob_head_ff;
         ev_src    = SRC_PROB;
      end else if (main_live) begin
         ev_victim = main_head_ff;
         ev_src    = SRC_MAIN;
         ev_main   = 1'b1;
      end else if (prob_live) begin
         ev_victim = prob_head_ff;
         ev_src    = SRC_PROB;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      func_in       = func_ff;
      item_in       = item_ff;
      sel_main_in   = sel_main_ff;
      src_in        = src_ff;
      old_tail_in   = old_tail_ff;
      prob_head_in  = prob_head_ff;
      prob_tail_in  = prob_tail_ff;
      main_head_in  = main_head_ff;
      main_tail_in  = main_tail_ff;
      prob_cnt_in   = prob_cnt_ff;
      main_cnt_in   = main_cnt_ff;
      limit_in      = csr_valid ? csr_probation_limit : limit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_victim_in = rsp_victim_ff;
      rsp_src_in    = rsp_src_ff;
      req_ready     = 1'b0;
      mem_we        = '0;
      mem_wr_addr   = item_ff;
      mem_wr_class  = CLASS_NONE;
      mem_wr_next   = NIL;
      mem_wr_prev   = NIL;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = req_idx;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = '{cls: 1'b1, nxt: 1'b1, prv: 1'b1};
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST) begin
               state_in = ST_READY;
            end
         end
         ST_READY: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in = req_func;
               if (req_func == FUNC_EVICT) begin
                  item_in     = ev_victim[IW-1:0];
                  src_in      = ev_src;
                  sel_main_in = ev_main;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ev_victim[IW-1:0];
                  state_in    = ST_READ;
               end else if (req_in_range) begin
                  item_in     = req_idx;
                  mem_rd_en   = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_READ: begin
            if ((func_ff == FUNC_REF) && (mem_rd_class == CLASS_NONE)) begin
               // new frame joins the probationary tail
               mem_we       = '{cls: 1'b1, nxt: 1'b1, prv: 1'b1};
               mem_wr_class = CLASS_PROB;
               mem_wr_prev  = prob_live ? prob_tail_ff : NIL;
               old_tail_in  = prob_live ? prob_tail_ff : NIL;
               if (!prob_live) begin
                  prob_head_in = LW'(item_ff);
               end
               prob_tail_in = LW'(item_ff);
               prob_cnt_in  = prob_cnt_ff + 1'b1;
               state_in     = ST_LINK;
            end else if ((func_ff == FUNC_EVICT) && (src_ff == SRC_NONE)) begin
               state_in = ST_RETIRE;
            end else begin
               // unlink, forward half: predecessor's next or the queue head
               sel_main_in = rd_sel_main;
               if (mem_rd_prev < NIL) begin
                  mem_we.nxt  = 1'b1;
                  mem_wr_addr = mem_rd_prev[IW-1:0];
                  mem_wr_next = mem_rd_next;
               end else if (rd_sel_main) begin
                  main_head_in = mem_rd_next;
               end else begin
                  prob_head_in = mem_rd_next;
               end
               state_in = ST_UNLINK;
            end
         end
         ST_UNLINK: begin
            // unlink, backward half: successor's prev or the queue tail
            if (mem_rd_next < NIL) begin
               mem_we.prv  = 1'b1;
               mem_wr_addr = mem_rd_next[IW-1:0];
               mem_wr_prev = mem_rd_prev;
            end else if (sel_main_ff) begin
               main_tail_in = mem_rd_prev;
            end else begin
               prob_tail_in = mem_rd_prev;
            end
            if (sel_main_ff) begin
               if (main_cnt_ff != '0) begin
                  main_cnt_in = main_cnt_ff - 1'b1;
               end
            end else if (prob_cnt_ff != '0) begin
               prob_cnt_in = prob_cnt_ff - 1'b1;
            end
            state_in = (func_ff == FUNC_REF) ? ST_APPEND : ST_RETIRE;
         end
         ST_APPEND: begin
            mem_we       = '{cls: 1'b1, nxt: 1'b1, prv: 1'b1};
            mem_wr_class = CLASS_MAIN;
            mem_wr_prev  = main_live ? main_tail_ff : NIL;
            old_tail_in  = main_live ? main_tail_ff : NIL;
            if (!main_live) begin
               main_head_in = LW'(item_ff);
            end
            main_tail_in = LW'(item_ff);
            main_cnt_in  = main_cnt_ff + 1'b1;
            state_in     = ST_LINK;
         end
         ST_LINK: begin
            if (old_tail_ff < NIL) begin
               mem_we.nxt  = 1'b1;
               mem_wr_addr = old_tail_ff[IW-1:0];
               mem_wr_next = LW'(item_ff);
            end
            state_in = ST_READY;
         end
         ST_RETIRE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               mem_we        = '{cls: 1'b1, nxt: 1'b1, prv: 1'b1};
               rsp_valid_in  = 1'b1;
               rsp_victim_in = FRAME_W'(item_ff);
               rsp_src_in    = src_ff;
               state_in      = ST_READY;
            end
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         prob_head_ff <= NIL;
         prob_tail_ff <= NIL;
         main_head_ff <= NIL;
         main_tail_ff <= NIL;
         prob_cnt_ff  <= '0;
         main_cnt_ff  <= '0;
         limit_ff     <= LIMIT_W'(LIMIT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         prob_head_ff <= prob_head_in;
         prob_tail_ff <= prob_tail_in;
         main_head_ff <= main_head_in;
         main_tail_ff <= main_tail_in;
         prob_cnt_ff  <= prob_cnt_in;
         main_cnt_ff  <= main_cnt_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      item_ff       <= item_in;
      sel_main_ff   <= sel_main_in;
      src_ff        <= src_in;
      old_tail_ff   <= old_tail_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_src_ff    <= rsp_src_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_victim        = rsp_victim_ff;
   assign rsp_victim_source = rsp_src_ff;

endmodule

`default_nettype wire

FILE: design/two_queue_page_replacement_unit.sv
// two-queue page replacement unit
// tracks FRAMES frames in a probationary fifo and a main fifo (doubly linked,
// links and class of every frame held in one synchronous frame memory)
// req channel: one word is func plus frame; func ref touches a frame, func evict
//   asks for a victim. references to frames at or above FRAMES are dropped
// rsp channel: one word per evict, victim frame and its source
//   (probationary head, main head, or frame 0 when both queues are empty)
// csr channel: writes probation_limit; always ready, write only while idle
// steps per word, set by the one write port of the frame memory:
//   reference to a new frame: read, append, link old tail; reference to a queued
//   frame: read, unlink forward, unlink backward, append, link old tail; evict:
//   read, both unlink halves, retire; evict, both queues empty: read, retire
// evict result: registered out of the retire step; a new word is taken only
//   once the steps of the last word are done
// reset: synchronous; afterwards a clearing pass writes every frame memory
//   entry in turn, req ready stays low until it ends; probation_limit resets
//   to FRAMES/10 (at least 1, at most LIMIT_MAX)
// stall: a held result word sits in the output register while the next word
//   is taken; a second evict waits in its last step until the register frees
`default_nettype none

module two_queue_page_replacement_unit #(
   parameter int unsigned FRAMES = tqpr_pkg::FRAMES_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   tqpr_req_if.sink   req_bus,
   tqpr_rsp_if.source rsp_bus,
   tqpr_csr_if.sink   csr_bus
);
   import tqpr_pkg::*;

   localparam int unsigned IW = $clog2(FRAMES);
   localparam int unsigned LW = $clog2(FRAMES + 1);

   // frame memory port
   mem_we_type     mem_we;
   logic [IW-1:0]  mem_wr_addr;
   class_type      mem_wr_class;
   logic [LW-1:0]  mem_wr_next;
   logic [LW-1:0]  mem_wr_prev;
   logic           mem_rd_en;
   logic [IW-1:0]  mem_rd_addr;
   class_type      mem_rd_class;
   logic [LW-1:0]  mem_rd_next;
   logic [LW-1:0]  mem_rd_prev;

   // the limit register takes any write
   assign csr_bus.ready = 1'b1;

   // sequencer: queue pointers, counts, limit and the per-word step order
   tqpr_seq #(
      .FRAMES (FRAMES)
   ) u_seq (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_bus.valid),
      .req_ready           (req_bus.ready),
      .req_func            (req_bus.func),
      .req_frame           (req_bus.frame),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_victim          (rsp_bus.victim),
      .rsp_victim_source   (rsp_bus.victim_source),
      .csr_valid           (csr_bus.valid),
      .csr_probation_limit (csr_bus.probation_limit),
      .mem_we              (mem_we),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_class        (mem_wr_class),
      .mem_wr_next         (mem_wr_next),
      .mem_wr_prev         (mem_wr_prev),
      .mem_rd_en           (mem_rd_en),
      .mem_rd_addr         (mem_rd_addr),
      .mem_rd_class        (mem_rd_class),
      .mem_rd_next         (mem_rd_next),
      .mem_rd_prev         (mem_rd_prev)
   );

   // frame memory: class, next and prev of every frame, registered read
   tqpr_link_mem #(
      .FRAMES (FRAMES)
   ) u_mem (
      .clock    (clock),
      .we       (mem_we),
      .wr_addr  (mem_wr_addr),
      .wr_class (mem_wr_class),
      .wr_next  (mem_wr_next),
      .wr_prev  (mem_wr_prev),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_class (mem_rd_class),
      .rd_next  (mem_rd_next),
      .rd_prev  (mem_rd_prev)
   );

endmodule

`default_nettype wire

FILE: design/tqpr_checker.sv
`default_nettype none

module tqpr_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_ready,
   input wire                                rsp_valid,
   input wire                                rsp_ready,
   input wire [tqpr_pkg::FRAME_W-1:0]        rsp_victim,
   input wire [tqpr_pkg::SOURCE_W-1:0]       rsp_victim_source
);
   import tqpr_pkg::*;

   // held result word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // held result word keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_victim) && $stable(rsp_victim_source))
      else $error("result word changed while stalled");

   // fallback victim is always frame 0
   a_fallback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_victim_source == SRC_NONE) |-> rsp_victim == '0)
      else $error("fallback victim is not frame 0");

   // clearing pass blocks requests and no result is shown right after reset
   a_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("block active during reset or clearing start");

endmodule

bind two_queue_page_replacement_unit tqpr_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_victim        (rsp_bus.victim),
   .rsp_victim_source (rsp_bus.victim_source)
);

`default_nettype wire

FILE: tb/two_queue_page_replacement_unit_tb.sv
`timescale 1ns / 1ps

module two_queue_page_replacement_unit_tb;
   import tqpr_pkg::*;

   localparam int unsigned FRAMES       = FRAMES_DEFAULT;
   localparam int unsigned LINK_W       = FRAME_W + 1;
   localparam logic [LINK_W-1:0] NIL    = LINK_W'(FRAMES);
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned IDLE_PCT     = 33;
   localparam int unsigned MAX_REPORTS  = 10;

   // one request word and one victim word
   typedef struct {
      logic               func;
      logic [FRAME_W-1:0] frame;
   } page_word_type;

   typedef struct {
      logic [FRAME_W-1:0]  victim;
      logic [SOURCE_W-1:0] source;
   } victim_word_type;

   logic clock;
   logic reset;

   tqpr_req_if req_bus ();
   tqpr_rsp_if rsp_bus ();
   tqpr_csr_if csr_bus ();

   two_queue_page_replacement_unit #(
      .FRAMES (FRAMES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // words waiting to be offered, and victims the block still owes us
   page_word_type   page_words_waiting [$];
   victim_word_type victims_due [$];

   int unsigned error_count;
   int unsigned cycles_run;

   // knobs the stimulus flips per phase
   bit no_idle;
   bit hold_request;
   bit hold_done;
   int unsigned hold_left;

   // shadow copy of the replacement state
   class_type         frame_cls  [FRAMES];
   logic [LINK_W-1:0] frame_next [FRAMES];
   logic [LINK_W-1:0] frame_prev [FRAMES];
   logic [LINK_W-1:0] q_head [3];
   logic [LINK_W-1:0] q_tail [3];
   int unsigned       q_len  [3];
   logic [LIMIT_W-1:0] limit_shadow;

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // ---------------------------------------------------------------------
   // shadow model of the two fifos
   // ---------------------------------------------------------------------

   function automatic void clear_page_state();
      int i;
      for (i = 0; i < FRAMES; i++) begin
         frame_cls[i]  = CLASS_NONE;
         frame_next[i] = NIL;
         frame_prev[i] = NIL;
      end
      for (i = 0; i < 3; i++) begin
         q_head[i] = NIL;
         q_tail[i] = NIL;
         q_len[i]  = 0;
      end
      // reset value is FRAMES/10, at least 1
      limit_shadow = (FRAMES / 10 == 0) ? LIMIT_W'(1) : LIMIT_W'(FRAMES / 10);
   endfunction

   // put a frame at the tail of one fifo
   function automatic void link_at_tail(class_type q, logic [FRAME_W-1:0] f);
      frame_next[f] = NIL;
      if (q_head[q] == NIL) begin
         frame_prev[f] = NIL;
         q_head[q] = {1'b0, f};
      end else begin
         frame_prev[f] = q_tail[q];
         frame_next[q_tail[q]] = {1'b0, f};
      end
      q_tail[q] = {1'b0, f};
      q_len[q]++;
   endfunction

   // take a frame out of wherever it sits in a fifo
   function automatic void unlink_frame(class_type q, logic [FRAME_W-1:0] f);
      logic [LINK_W-1:0] p;
      logic [LINK_W-1:0] n;
      p = frame_prev[f];
      n = frame_next[f];
      if (p != NIL) frame_next[p] = n;
      else q_head[q] = n;
      if (n != NIL) frame_prev[n] = p;
      else q_tail[q] = p;
      frame_next[f] = NIL;
      frame_prev[f] = NIL;
      if (q_len[q] > 0) q_len[q]--;
   endfunction

   // apply one accepted request word, queue the victim an evict will return
   function automatic void page_queues_step(logic func, logic [FRAME_W-1:0] f);
      class_type       pick;
      victim_word_type v;
      if (func == FUNC_REF) begin
         // frames past the end are dropped
         if (int'(f) >= FRAMES) return;
         case (frame_cls[f])
            CLASS_NONE: begin
               link_at_tail(CLASS_PROB, f);
               frame_cls[f] = CLASS_PROB;
            end
            CLASS_PROB: begin
               unlink_frame(CLASS_PROB, f);
               link_at_tail(CLASS_MAIN, f);
               frame_cls[f] = CLASS_MAIN;
            end
            default: begin
               unlink_frame(CLASS_MAIN, f);
               link_at_tail(CLASS_MAIN, f);
            end
         endcase
         return;
      end
      // probationary first only when it is over the limit
      if (q_len[CLASS_PROB] > int'(limit_shadow) && q_head[CLASS_PROB] != NIL)
         pick = CLASS_PROB;
      else if (q_head[CLASS_MAIN] != NIL)
         pick = CLASS_MAIN;
      else if (q_head[CLASS_PROB] != NIL)
         pick = CLASS_PROB;
      else
         pick = CLASS_NONE;
      if (pick == CLASS_NONE) begin
         // both fifos empty, fall back to frame 0
         v.victim = '0;
         v.source = SRC_NONE;
      end else begin
         v.victim = q_head[pick][FRAME_W-1:0];
         v.source = (pick == CLASS_PROB) ? SRC_PROB : SRC_MAIN;
         unlink_frame(pick, v.victim);
      end
      frame_cls[v.victim]  = CLASS_NONE;
      frame_next[v.victim] = NIL;
      frame_prev[v.victim] = NIL;
      victims_due.push_back(v);
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("mismatch: %s", msg);
   endtask

   // ---------------------------------------------------------------------
   // request driver: offers waiting words, predicts each accepted one
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            page_queues_step(req_bus.func, req_bus.frame);
         // slot is free when nothing is offered or the offer just went through
         if (!req_bus.valid || req_bus.ready) begin
            if (page_words_waiting.size() != 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               req_bus.valid <= 1'b1;
               req_bus.func  <= page_words_waiting[0].func;
               req_bus.frame <= page_words_waiting[0].frame;
               void'(page_words_waiting.pop_front());
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // result monitor: compares each victim word with the oldest one due
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (victims_due.size() == 0) begin
               flag_error($sformatf("victim %0d source %0d with none due",
                                    rsp_bus.victim, rsp_bus.victim_source));
            end else begin
               if (rsp_bus.victim !== victims_due[0].victim)
                  flag_error($sformatf("victim expected %0d, got %0d",
                                       victims_due[0].victim, rsp_bus.victim));
               if (rsp_bus.victim_source !== victims_due[0].source)
                  flag_error($sformatf("victim_source expected %0d, got %0d",
                                       victims_due[0].source, rsp_bus.victim_source));
               void'(victims_due.pop_front());
            end
         end
         // long hold-off wins, otherwise random stalls unless idling is off
         rsp_bus.ready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= IDLE_PCT);
      end
   end

   // receiver hold-off, counted here so the sender keeps offering meanwhile
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles_run <= cycles_run + 1;
      if (cycles_run >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic void queue_word(logic func, logic [FRAME_W-1:0] f);
      page_word_type w;
      w.func  = func;
      w.frame = f;
      page_words_waiting.push_back(w);
   endfunction

   // sender pause: everything accepted, every victim back, then let refs finish
   task automatic wait_until_drained();
      do @(negedge clock);
      while (page_words_waiting.size() != 0 || req_bus.valid || victims_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr write, only called while no words are in flight
   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      @(posedge clock);
      csr_bus.valid           <= 1'b1;
      csr_bus.probation_limit <= value;
      do @(posedge clock);
      while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      limit_shadow = value;
   endtask

   // random words drawn mostly from a small working set so frames come back
   // and get promoted; the rest are fully random frames
   task automatic random_phase(input int count, input int evict_pct, input int pool_size);
      logic [FRAME_W-1:0] pool [$];
      int i;
      @(negedge clock);
      for (i = 0; i < pool_size; i++) pool.push_back(FRAME_W'($urandom));
      for (i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            queue_word(($urandom_range(99) < evict_pct) ? FUNC_EVICT : FUNC_REF,
                       FRAME_W'($urandom));
         else
            queue_word(($urandom_range(99) < evict_pct) ? FUNC_EVICT : FUNC_REF,
                       pool[$urandom_range(pool.size() - 1)]);
      end
      wait_until_drained();
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                   = 1'b1;
      error_count             = 0;
      cycles_run              = 0;
      no_idle                 = 1'b0;
      hold_request            = 1'b0;
      req_bus.valid           = 1'b0;
      req_bus.func            = FUNC_REF;
      req_bus.frame           = '0;
      rsp_bus.ready           = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.probation_limit = '0;
      clear_page_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed words with a limit of one
      write_limit(LIMIT_W'(1));
      @(negedge clock);
      queue_word(FUNC_EVICT, 10'd0);      // both fifos empty, fallback to frame 0
      queue_word(FUNC_REF,   10'd0);
      queue_word(FUNC_REF,   10'd1023);
      queue_word(FUNC_REF,   10'd0);      // probationary to main
      queue_word(FUNC_REF,   10'd512);
      queue_word(FUNC_REF,   10'd1023);
      queue_word(FUNC_REF,   10'd0);      // main back to main tail
      queue_word(FUNC_EVICT, 10'd1023);   // main head
      queue_word(FUNC_EVICT, 10'd0);
      queue_word(FUNC_EVICT, 10'd0);      // main empty, probationary head
      queue_word(FUNC_EVICT, 10'd0);      // empty again
      queue_word(FUNC_REF,   10'd5);
      queue_word(FUNC_REF,   10'd6);
      queue_word(FUNC_REF,   10'd7);
      queue_word(FUNC_REF,   10'd6);      // promote from the middle of a fifo
      queue_word(FUNC_EVICT, 10'd0);      // probationary over the limit
      queue_word(FUNC_EVICT, 10'd0);
      queue_word(FUNC_EVICT, 10'd0);
      queue_word(FUNC_REF,   10'd1023);   // evicted frame comes back as new
      queue_word(FUNC_EVICT, 10'h3ff);
      queue_word(FUNC_EVICT, 10'h155);
      wait_until_drained();

      // zero limit: any probationary frame goes first
      write_limit('0);
      random_phase(70, 25, 12);

      // top of the register range with no idling on either side
      write_limit(LIMIT_W'(LIMIT_MAX));
      no_idle = 1'b1;
      random_phase(70, 30, 40);

      // receiver holds off while the sender keeps pushing, block backs up
      write_limit(LIMIT_W'(3));
      hold_request = 1'b1;
      random_phase(80, 50, 10);
      no_idle = 1'b0;

      // wide working set so the probationary fifo outgrows its limit
      write_limit(LIMIT_W'(60));
      random_phase(80, 10, 300);

      write_limit(LIMIT_W'($urandom_range(1, 30)));
      random_phase(75, 30, 24);

      write_limit(LIMIT_W'(1024));
      random_phase(75, 25, 16);

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
